[sv/ietsm_pkg.sv]
// Shared types, codes and the key-to-scancode table of the event translator.
`default_nettype none

package ietsm_pkg;

   // Default queue depths (each queue needs at least two entries)
   localparam int CMD_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 2;

   localparam int CSR_INDEX_WIDTH = 2;

   // Event classes
   localparam logic [15:0] EV_SYNC = 16'h0000;
   localparam logic [15:0] EV_KEY  = 16'h0001;
   localparam logic [15:0] EV_REL  = 16'h0002;

   // Button key codes
   localparam logic [15:0] CODE_LEFT_BUTTON   = 16'h0110;
   localparam logic [15:0] CODE_RIGHT_BUTTON  = 16'h0111;
   localparam logic [15:0] CODE_MIDDLE_BUTTON = 16'h0112;

   // Relative axes
   localparam logic [15:0] AXIS_X = 16'h0000;
   localparam logic [15:0] AXIS_Y = 16'h0001;

   localparam logic [7:0] RELEASE_BIT = 8'h80;

   // Configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LEFT_MASK   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RIGHT_MASK  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MIDDLE_MASK = 2'd2;

   // Result kinds
   localparam logic KIND_SCANCODE = 1'b0;
   localparam logic KIND_MOUSE    = 1'b1;

   typedef enum logic [1:0] {
      OP_KEY,
      OP_BUTTON,
      OP_REL,
      OP_SYNC
   } op_type;

   // Classified event handed from front to back
   typedef struct packed {
      op_type            op;
      logic [7:0]        scancode;
      logic [7:0]        mask;
      logic              press;
      logic              axis_x;
      logic              axis_y;
      logic signed [7:0] delta;
   } cmd_type;

   // One result item
   typedef struct packed {
      logic              kind;
      logic [7:0]        scancode;
      logic signed [7:0] delta_x;
      logic signed [7:0] delta_y;
      logic [7:0]        buttons;
   } rsp_type;

   function automatic logic [7:0] key_scancode(input logic [7:0] code);
      logic [7:0] sc;
      unique case (code)
         8'h04: sc = 8'h1e;  8'h05: sc = 8'h30;  8'h06: sc = 8'h2e;  8'h07: sc = 8'h20;
         8'h08: sc = 8'h12;  8'h09: sc = 8'h21;  8'h0a: sc = 8'h22;  8'h0b: sc = 8'h23;
         8'h0c: sc = 8'h17;  8'h0d: sc = 8'h24;  8'h0e: sc = 8'h25;  8'h0f: sc = 8'h26;
         8'h10: sc = 8'h32;  8'h11: sc = 8'h31;  8'h12: sc = 8'h18;  8'h13: sc = 8'h19;
         8'h14: sc = 8'h10;  8'h15: sc = 8'h13;  8'h16: sc = 8'h1f;  8'h17: sc = 8'h14;
         8'h18: sc = 8'h16;  8'h19: sc = 8'h2f;  8'h1a: sc = 8'h11;  8'h1b: sc = 8'h2d;
         8'h1c: sc = 8'h2c;  8'h1d: sc = 8'h15;  8'h1e: sc = 8'h02;  8'h1f: sc = 8'h03;
         8'h20: sc = 8'h04;  8'h21: sc = 8'h05;  8'h22: sc = 8'h06;  8'h23: sc = 8'h07;
         8'h24: sc = 8'h08;  8'h25: sc = 8'h09;  8'h26: sc = 8'h0a;  8'h27: sc = 8'h0b;
         8'h28: sc = 8'h1c;  8'h29: sc = 8'h01;  8'h2a: sc = 8'h0e;  8'h2b: sc = 8'h0f;
         8'h2c: sc = 8'h39;  8'h2d: sc = 8'h0c;  8'h2e: sc = 8'h0d;  8'h2f: sc = 8'h1a;
         8'h30: sc = 8'h1b;  8'h33: sc = 8'h27;  8'h34: sc = 8'h28;  8'h35: sc = 8'h29;
         8'h36: sc = 8'h33;  8'h37: sc = 8'h34;  8'h38: sc = 8'h35;  8'h39: sc = 8'h3a;
         8'h3a: sc = 8'h3b;  8'h3b: sc = 8'h3c;  8'h3c: sc = 8'h3d;  8'h3d: sc = 8'h3e;
         8'h3e: sc = 8'h3f;  8'h3f: sc = 8'h40;  8'h40: sc = 8'h41;  8'h41: sc = 8'h42;
         8'h42: sc = 8'h43;  8'h43: sc = 8'h44;  8'h44: sc = 8'h45;  8'h45: sc = 8'h46;
         8'h46: sc = 8'h47;  8'h47: sc = 8'h48;  8'h48: sc = 8'h49;  8'h49: sc = 8'h4a;
         8'h4a: sc = 8'h4b;  8'h4b: sc = 8'h4c;  8'h4c: sc = 8'h4d;  8'h4d: sc = 8'h4e;
         8'h4e: sc = 8'h4f;  8'h4f: sc = 8'h50;  8'h50: sc = 8'h51;  8'h51: sc = 8'h52;
         8'h52: sc = 8'h53;  8'h53: sc = 8'h1c;  8'h54: sc = 8'h35;  8'h55: sc = 8'h37;
         8'h56: sc = 8'h4a;  8'h57: sc = 8'h4e;  8'h58: sc = 8'h58;  8'h59: sc = 8'h4f;
         8'h5a: sc = 8'h50;  8'h5b: sc = 8'h51;  8'h5c: sc = 8'h4b;  8'h5d: sc = 8'h4c;
         8'h5e: sc = 8'h4d;  8'h5f: sc = 8'h47;  8'h60: sc = 8'h48;  8'h61: sc = 8'h49;
         8'h62: sc = 8'h52;  8'h63: sc = 8'h53;  8'he0: sc = 8'h1d;  8'he4: sc = 8'h1d;
         default: sc = 8'h00;
      endcase
      return sc;
   endfunction

endpackage

`default_nettype wire

[sv/ietsm_front.sv]
// Front end: configuration registers and classification of incoming events.
`default_nettype none

module ietsm_front
   import ietsm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire logic [15:0]                req_event_type,
   input  wire logic [15:0]                req_event_code,
   input  wire logic [31:0]                req_event_value,
   input  wire logic                       cmd_full,
   output logic                            cmd_push,
   output cmd_type                         cmd_data,
   input  wire logic                       csr_valid,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                 csr_wdata,
   output logic                            csr_ready
);

   logic [7:0] left_mask_ff,   left_mask_in;
   logic [7:0] right_mask_ff,  right_mask_in;
   logic [7:0] middle_mask_ff, middle_mask_in;

   logic       csr_write;
   logic       relevant;
   logic       is_release;
   logic [7:0] table_sc;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      left_mask_in   = left_mask_ff;
      right_mask_in  = right_mask_ff;
      middle_mask_in = middle_mask_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_LEFT_MASK:   left_mask_in   = csr_wdata;
            CSR_RIGHT_MASK:  right_mask_in  = csr_wdata;
            CSR_MIDDLE_MASK: middle_mask_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_mask_ff   <= 8'h01;
         right_mask_ff  <= 8'h02;
         middle_mask_ff <= 8'h04;
      end else begin
         left_mask_ff   <= left_mask_in;
         right_mask_ff  <= right_mask_in;
         middle_mask_ff <= middle_mask_in;
      end
   end

   // Codes of 256 and above never hit the table
   assign table_sc   = (req_event_code[15:8] == 8'h00) ?
                       key_scancode(req_event_code[7:0]) : 8'h00;
   assign is_release = (req_event_value == 32'h0);

   always_comb begin
      relevant          = 1'b0;
      cmd_data.op       = OP_SYNC;
      cmd_data.scancode = is_release ? (table_sc | RELEASE_BIT) : table_sc;
      cmd_data.mask     = middle_mask_ff;
      cmd_data.press    = ~is_release;
      cmd_data.axis_x   = (req_event_code == AXIS_X);
      cmd_data.axis_y   = (req_event_code == AXIS_Y);
      cmd_data.delta    = req_event_value[7:0];
      priority if (req_event_type == EV_KEY) begin
         priority if (req_event_code == CODE_LEFT_BUTTON) begin
            relevant      = 1'b1;
            cmd_data.op   = OP_BUTTON;
            cmd_data.mask = left_mask_ff;
         end else if (req_event_code == CODE_RIGHT_BUTTON) begin
            relevant      = 1'b1;
            cmd_data.op   = OP_BUTTON;
            cmd_data.mask = right_mask_ff;
         end else if (req_event_code == CODE_MIDDLE_BUTTON) begin
            relevant      = 1'b1;
            cmd_data.op   = OP_BUTTON;
         end else if (table_sc != 8'h00) begin
            relevant    = 1'b1;
            cmd_data.op = OP_KEY;
         end else begin
            relevant = 1'b0;
         end
      end else if (req_event_type == EV_REL) begin
         relevant    = 1'b1;
         cmd_data.op = OP_REL;
      end else if (req_event_type == EV_SYNC) begin
         relevant    = 1'b1;
         cmd_data.op = OP_SYNC;
      end else begin
         relevant = 1'b0;
      end
   end

   // Drop events that can have no effect
   assign cmd_push = req_push & ~cmd_full & relevant;

endmodule

`default_nettype wire

[sv/ietsm_cmd_queue.sv]
// Short command queue between the front and back ends.
`default_nettype none

module ietsm_cmd_queue
   import ietsm_pkg::*;
#(
   parameter int DEPTH = CMD_DEPTH_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  cmd_type      push_data,
   input  wire logic    pop,
   output logic         empty,
   output logic         full,
   output cmd_type      head
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff,  count_in;
   logic            do_push, do_pop;

   assign empty   = (count_ff == CW'(0));
   assign full    = (count_ff == CW'(DEPTH));
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[sv/ietsm_back.sv]
// Back end: mouse state, command execution and the result queue.
`default_nettype none

module ietsm_back
   import ietsm_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          cmd_empty,
   input  cmd_type            cmd_head,
   output logic               cmd_pop,
   input  wire logic          rsp_pop,
   output logic               rsp_empty,
   output logic               rsp_result_kind,
   output logic [7:0]         rsp_scancode,
   output logic signed [7:0]  rsp_delta_x,
   output logic signed [7:0]  rsp_delta_y,
   output logic [7:0]         rsp_buttons
);

   localparam int PW = $clog2(RSP_DEPTH);
   localparam int CW = $clog2(RSP_DEPTH + 1);

   logic signed [7:0] acc_x_ff,   acc_x_in;
   logic signed [7:0] acc_y_ff,   acc_y_in;
   logic [7:0]        buttons_ff, buttons_in;
   logic              pending_ff, pending_in;

   rsp_type           slot_ff [RSP_DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff,  count_in;

   logic              rsp_push;
   rsp_type           rsp_data;
   rsp_type           rsp_head;
   logic              do_pop;

   // Execute one command whenever the result queue has room
   assign cmd_pop = ~cmd_empty & (count_ff != CW'(RSP_DEPTH));

   always_comb begin
      acc_x_in          = acc_x_ff;
      acc_y_in          = acc_y_ff;
      buttons_in        = buttons_ff;
      pending_in        = pending_ff;
      rsp_push          = 1'b0;
      rsp_data.kind     = KIND_SCANCODE;
      rsp_data.scancode = cmd_head.scancode;
      rsp_data.delta_x  = '0;
      rsp_data.delta_y  = '0;
      rsp_data.buttons  = '0;
      if (cmd_pop) begin
         unique case (cmd_head.op)
            OP_KEY: begin
               rsp_push = 1'b1;
            end
            OP_BUTTON: begin
               buttons_in = cmd_head.press ? (buttons_ff | cmd_head.mask) :
                                             (buttons_ff & ~cmd_head.mask);
               pending_in = 1'b1;
            end
            OP_REL: begin
               if (cmd_head.axis_x) begin
                  acc_x_in = acc_x_ff + cmd_head.delta;
               end
               if (cmd_head.axis_y) begin
                  acc_y_in = acc_y_ff + cmd_head.delta;
               end
               pending_in = 1'b1;
            end
            OP_SYNC: begin
               if (pending_ff) begin
                  rsp_push          = 1'b1;
                  rsp_data.kind     = KIND_MOUSE;
                  rsp_data.scancode = '0;
                  rsp_data.delta_x  = acc_x_ff;
                  rsp_data.delta_y  = acc_y_ff;
                  rsp_data.buttons  = buttons_ff;
                  acc_x_in          = '0;
                  acc_y_in          = '0;
                  pending_in        = 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_x_ff   <= '0;
         acc_y_ff   <= '0;
         buttons_ff <= '0;
         pending_ff <= 1'b0;
      end else begin
         acc_x_ff   <= acc_x_in;
         acc_y_ff   <= acc_y_in;
         buttons_ff <= buttons_in;
         pending_ff <= pending_in;
      end
   end

   // Result queue
   assign rsp_empty = (count_ff == CW'(0));
   assign do_pop    = rsp_pop & ~rsp_empty;
   assign rsp_head  = slot_ff[rd_ptr_ff];

   assign rsp_result_kind = rsp_head.kind;
   assign rsp_scancode    = rsp_head.scancode;
   assign rsp_delta_x     = rsp_head.delta_x;
   assign rsp_delta_y     = rsp_head.delta_y;
   assign rsp_buttons     = rsp_head.buttons;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(RSP_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(RSP_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (rsp_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !rsp_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_push) begin
         slot_ff[wr_ptr_ff] <= rsp_data;
      end
   end

endmodule

`default_nettype wire

[sv/input_event_to_scancode_mouse_core.sv]
// Top level of the input event translator: front end, command queue, back end.
//
// Translates input events (type, code, value) into set-1 keyboard scancodes
// and mouse packets. A key event whose code is in the built-in key table
// yields one scancode transaction, with bit 7 set on release (value zero).
// Key codes 0x110, 0x111 and 0x112 are the left, right and middle buttons:
// they set (press) or clear (release) the bits of the matching mask register
// in the kept button mask and mark the mouse state pending. A relative event
// adds the signed low byte of its value to the X (code 0) or Y (code 1)
// delta, wrapping at 8 bits, and marks pending. A sync event while pending
// yields one mouse packet transaction with both deltas and the button mask,
// then clears the deltas and the pending flag. Other events are dropped.
// Both sides behave as queues: push/full on the request side, empty/pop on
// the response side. The front end classifies one event per cycle into a
// command queue of CMD_DEPTH entries; the back end executes one command per
// cycle into a result queue of RSP_DEPTH entries, so the block sustains one
// event per clock as long as results are popped at the same rate. From push
// to result an event is registered in the command queue and then in the
// result queue. Mask registers are written through the csr_ port, which is
// always ready; write them only while no event is in flight.
`default_nettype none

module input_event_to_scancode_mouse_core
   import ietsm_pkg::*;
#(
   parameter int CMD_DEPTH = CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   // Event requests
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic [15:0]                req_event_type,
   input  wire logic [15:0]                req_event_code,
   input  wire logic [31:0]                req_event_value,
   // Results
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic                            rsp_result_kind,
   output logic [7:0]                      rsp_scancode,
   output logic signed [7:0]               rsp_delta_x,
   output logic signed [7:0]               rsp_delta_y,
   output logic [7:0]                      rsp_buttons,
   // Mask register writes
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [7:0]                 csr_wdata
);

   logic    cmd_push;
   cmd_type cmd_push_data;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;
   cmd_type cmd_head;

   // Hold off the requester only when the command queue is full
   assign req_full = cmd_full;

   ietsm_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_event_type  (req_event_type),
      .req_event_code  (req_event_code),
      .req_event_value (req_event_value),
      .cmd_full        (cmd_full),
      .cmd_push        (cmd_push),
      .cmd_data        (cmd_push_data),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .csr_ready       (csr_ready)
   );

   ietsm_cmd_queue #(
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .full      (cmd_full),
      .head      (cmd_head)
   );

   ietsm_back #(
      .RSP_DEPTH (RSP_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_empty       (cmd_empty),
      .cmd_head        (cmd_head),
      .cmd_pop         (cmd_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_result_kind (rsp_result_kind),
      .rsp_scancode    (rsp_scancode),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_buttons     (rsp_buttons)
   );

endmodule

`default_nettype wire

[bench/tb.sv]
// Self-checking testbench for the input event translator core.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ietsm_pkg::*;

   // Cycles to let the pipeline settle once no result is outstanding (two-stage path plus slack)
   localparam int SETTLE_CYCLES = 6;
   // Hard stop for the watchdog
   localparam int CYCLE_LIMIT   = 300000;
   // Handled events in the random part, split over its phases
   localparam int RANDOM_EVENTS = 1000;
   localparam int RANDOM_PHASES = 6;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [15:0]                req_event_type = '0;
   logic [15:0]                req_event_code = '0;
   logic [31:0]                req_event_value = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic                       rsp_result_kind;
   logic [7:0]                 rsp_scancode;
   logic signed [7:0]          rsp_delta_x;
   logic signed [7:0]          rsp_delta_y;
   logic [7:0]                 rsp_buttons;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [7:0]                 csr_wdata = '0;

   input_event_to_scancode_mouse_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_event_type  (req_event_type),
      .req_event_code  (req_event_code),
      .req_event_value (req_event_value),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_result_kind (rsp_result_kind),
      .rsp_scancode    (rsp_scancode),
      .rsp_delta_x     (rsp_delta_x),
      .rsp_delta_y     (rsp_delta_y),
      .rsp_buttons     (rsp_buttons),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor state: mirror of the translator's kept mouse state and masks
   // ---------------------------------------------------------------------
   logic [7:0] mask_reg [0:3];
   logic [7:0] kept_dx;
   logic [7:0] kept_dy;
   logic [7:0] kept_buttons;
   logic       packet_pending;

   // Results that accepted events have caused and that have not been popped yet, oldest first
   rsp_type    awaited_results [$];

   int         errors = 0;
   int         handled_events = 0;
   int         cycle_count = 0;
   // When set, neither side inserts idle cycles
   logic       steady_flow = 1'b0;

   initial begin
      mask_reg[CSR_LEFT_MASK]   = 8'h01;
      mask_reg[CSR_RIGHT_MASK]  = 8'h02;
      mask_reg[CSR_MIDDLE_MASK] = 8'h04;
      mask_reg[3]               = 8'h00;
      kept_dx        = '0;
      kept_dy        = '0;
      kept_buttons   = '0;
      packet_pending = 1'b0;
   end

   // Set-1 scancode for a keyboard usage code; zero where the usage has no mapping.
   function automatic logic [7:0] set1_scancode(input logic [7:0] code);
      logic [7:0] sc;
      sc = 8'h00;
      // Digit row 1..0 is a straight offset
      if (code >= 8'h1e && code <= 8'h27)
         sc = code - 8'h1c;
      // Caps lock, function keys, navigation cluster and keypad start run one apart
      else if (code >= 8'h39 && code <= 8'h52)
         sc = code + 8'h01;
      else case (code)
         8'h04: sc = 8'h1e;  8'h05: sc = 8'h30;  8'h06: sc = 8'h2e;  8'h07: sc = 8'h20;
         8'h08: sc = 8'h12;  8'h09: sc = 8'h21;  8'h0a: sc = 8'h22;  8'h0b: sc = 8'h23;
         8'h0c: sc = 8'h17;  8'h0d: sc = 8'h24;  8'h0e: sc = 8'h25;  8'h0f: sc = 8'h26;
         8'h10: sc = 8'h32;  8'h11: sc = 8'h31;  8'h12: sc = 8'h18;  8'h13: sc = 8'h19;
         8'h14: sc = 8'h10;  8'h15: sc = 8'h13;  8'h16: sc = 8'h1f;  8'h17: sc = 8'h14;
         8'h18: sc = 8'h16;  8'h19: sc = 8'h2f;  8'h1a: sc = 8'h11;  8'h1b: sc = 8'h2d;
         8'h1c: sc = 8'h2c;  8'h1d: sc = 8'h15;
         8'h28: sc = 8'h1c;  8'h29: sc = 8'h01;  8'h2a: sc = 8'h0e;  8'h2b: sc = 8'h0f;
         8'h2c: sc = 8'h39;  8'h2d: sc = 8'h0c;  8'h2e: sc = 8'h0d;  8'h2f: sc = 8'h1a;
         8'h30: sc = 8'h1b;  8'h33: sc = 8'h27;  8'h34: sc = 8'h28;  8'h35: sc = 8'h29;
         8'h36: sc = 8'h33;  8'h37: sc = 8'h34;  8'h38: sc = 8'h35;
         8'h53: sc = 8'h1c;  8'h54: sc = 8'h35;  8'h55: sc = 8'h37;  8'h56: sc = 8'h4a;
         8'h57: sc = 8'h4e;  8'h58: sc = 8'h58;  8'h59: sc = 8'h4f;  8'h5a: sc = 8'h50;
         8'h5b: sc = 8'h51;  8'h5c: sc = 8'h4b;  8'h5d: sc = 8'h4c;  8'h5e: sc = 8'h4d;
         8'h5f: sc = 8'h47;  8'h60: sc = 8'h48;  8'h61: sc = 8'h49;  8'h62: sc = 8'h52;
         8'h63: sc = 8'h53;  8'he0: sc = 8'h1d;  8'he4: sc = 8'h1d;
         default: sc = 8'h00;
      endcase
      return sc;
   endfunction

   // Advance the predicted state by one accepted event and queue the result it causes, if any.
   function automatic void translate_event(input logic [15:0] etype, input logic [15:0] ecode,
                                           input logic [31:0] evalue);
      rsp_type    res;
      logic [7:0] sc;
      logic [7:0] bits;
      res = '0;
      if (etype == EV_KEY) begin
         sc = (ecode < 16'h0100) ? set1_scancode(ecode[7:0]) : 8'h00;
         if (ecode == CODE_LEFT_BUTTON || ecode == CODE_RIGHT_BUTTON ||
             ecode == CODE_MIDDLE_BUTTON) begin
            bits = (ecode == CODE_LEFT_BUTTON)  ? mask_reg[CSR_LEFT_MASK] :
                   (ecode == CODE_RIGHT_BUTTON) ? mask_reg[CSR_RIGHT_MASK] :
                                                  mask_reg[CSR_MIDDLE_MASK];
            // Overlapping masks: plain OR on press, AND-NOT on release
            if (evalue != 32'h0)
               kept_buttons = kept_buttons | bits;
            else
               kept_buttons = kept_buttons & ~bits;
            packet_pending = 1'b1;
         end
         if (sc != 8'h00) begin
            res.kind     = KIND_SCANCODE;
            res.scancode = (evalue == 32'h0) ? (sc | RELEASE_BIT) : sc;
            awaited_results.push_back(res);
         end
      end else if (etype == EV_REL) begin
         // Any other axis leaves both deltas alone but still marks the mouse dirty
         if (ecode == AXIS_X)
            kept_dx = kept_dx + evalue[7:0];
         if (ecode == AXIS_Y)
            kept_dy = kept_dy + evalue[7:0];
         packet_pending = 1'b1;
      end else if (etype == EV_SYNC && packet_pending) begin
         res.kind    = KIND_MOUSE;
         res.delta_x = kept_dx;
         res.delta_y = kept_dy;
         res.buttons = kept_buttons;
         awaited_results.push_back(res);
         kept_dx        = '0;
         kept_dy        = '0;
         packet_pending = 1'b0;
      end
   endfunction

   // Idle cycles before the next transaction on either side
   function automatic int draw_gap();
      return steady_flow ? 0 : $urandom_range(0, 10);
   endfunction

   // ---------------------------------------------------------------------
   // Result side: pop with random stalls and compare against the oldest expectation
   // ---------------------------------------------------------------------
   task automatic compare_field(input string what, input logic [7:0] want, input logic [7:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, what, want, got);
         errors++;
      end
   endtask

   task automatic check_result();
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $display("%0t ns: unexpected result, actual kind %0d scancode %h dx %h dy %h buttons %h",
                  $time, rsp_result_kind, rsp_scancode, rsp_delta_x, rsp_delta_y, rsp_buttons);
         errors++;
      end else begin
         want = awaited_results.pop_front();
         compare_field("result_kind", {7'd0, want.kind}, {7'd0, rsp_result_kind});
         compare_field("scancode", want.scancode, rsp_scancode);
         compare_field("delta_x", want.delta_x, rsp_delta_x);
         compare_field("delta_y", want.delta_y, rsp_delta_y);
         compare_field("buttons", want.buttons, rsp_buttons);
      end
   endtask

   int pop_hold = 0;

   always @(posedge clock) begin : result_side
      int gap;
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (rsp_pop && !rsp_empty) begin
         // A transaction completes at this edge: check it, then decide how long to hold off
         check_result();
         gap = draw_gap();
         if (gap > 0) begin
            rsp_pop  <= 1'b0;
            pop_hold <= gap - 1;
         end
      end else if (!rsp_pop) begin
         if (pop_hold == 0)
            rsp_pop <= 1'b1;
         else
            pop_hold <= pop_hold - 1;
      end
   end

   // Watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------
   // Present one event after a random gap, hold it until accepted, then predict it.
   // Push is left high on return so back-to-back events need no extra edge.
   task automatic send_event(input logic [15:0] etype, input logic [15:0] ecode,
                             input logic [31:0] evalue);
      int gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_event_type  <= etype;
      req_event_code  <= ecode;
      req_event_value <= evalue;
      do @(posedge clock); while (req_full);
      translate_event(etype, ecode, evalue);
      if (etype <= EV_REL)
         handled_events++;
   endtask

   // Drop push, wait until every predicted result has been popped, then let the
   // pipeline drain events that cause no result.
   task automatic wait_idle();
      req_push <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Raise the register write channel and hold it until the write is taken; valid stays high.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [7:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      mask_reg[idx] = data;
   endtask

   // Write all three button masks back to back; call only while the block is idle.
   task automatic load_masks(input logic [7:0] l_mask, input logic [7:0] r_mask,
                             input logic [7:0] m_mask);
      write_csr(CSR_LEFT_MASK, l_mask);
      write_csr(CSR_RIGHT_MASK, r_mask);
      write_csr(CSR_MIDDLE_MASK, m_mask);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Key presses and releases: table ends, unmapped codes, value extremes
   task automatic test_key_events();
      send_event(EV_KEY, 16'h0004, 32'h0000_0001);   // first table entry, press
      send_event(EV_KEY, 16'h0004, 32'h0000_0000);   // release sets the top bit
      send_event(EV_KEY, 16'h00e4, 32'hffff_ffff);   // last table entry, all value bits
      send_event(EV_KEY, 16'h0063, 32'h0000_0100);   // low byte zero is still a press
      send_event(EV_KEY, 16'h0000, 32'h0000_0001);   // unmapped low code
      send_event(EV_KEY, 16'h0031, 32'h0000_0000);   // hole inside the table
      send_event(EV_KEY, 16'hffff, 32'h8000_0000);   // code beyond the table
   endtask

   // Button press/release with reset masks, then packets
   task automatic test_buttons();
      send_event(EV_KEY, CODE_LEFT_BUTTON, 32'h0000_0001);
      send_event(EV_KEY, CODE_RIGHT_BUTTON, 32'h0000_0002);
      send_event(EV_KEY, CODE_MIDDLE_BUTTON, 32'h8000_0000);
      send_event(EV_SYNC, 16'h0000, 32'h0000_0000);
      send_event(EV_KEY, CODE_LEFT_BUTTON, 32'h0000_0000);
      send_event(EV_SYNC, 16'hffff, 32'hffff_ffff);
   endtask

   // Relative motion with wrap, other axes, idle sync and ignored types
   task automatic test_relative();
      send_event(EV_REL, AXIS_X, 32'h0000_007f);
      send_event(EV_REL, AXIS_X, 32'hffff_ff7f);     // wraps past +127
      send_event(EV_REL, AXIS_Y, 32'h1234_5680);     // most negative step
      send_event(EV_REL, 16'h0002, 32'h0000_0005);   // other axis: only marks dirty
      send_event(EV_SYNC, 16'h0000, 32'h0000_0000);
      send_event(EV_SYNC, 16'h0000, 32'h0000_0000);  // nothing pending any more
      send_event(16'h0003, AXIS_X, 32'h0000_0001);   // ignored type
      send_event(16'hffff, 16'hffff, 32'hffff_ffff); // ignored type, all bits high
      send_event(EV_REL, 16'hffff, 32'h0000_0000);   // dirty via far axis code
      send_event(EV_SYNC, 16'h0000, 32'h0000_0000);
   endtask

   // Mask registers: empty, full and overlapping masks
   task automatic test_mask_registers();
      wait_idle();
      load_masks(8'h00, 8'hff, 8'h81);
      send_event(EV_KEY, CODE_LEFT_BUTTON, 32'h0000_0001);   // empty mask changes nothing
      send_event(EV_KEY, CODE_RIGHT_BUTTON, 32'h0000_0001);  // all bits set
      send_event(EV_KEY, CODE_MIDDLE_BUTTON, 32'h0000_0000); // clears bits shared with right
      send_event(EV_SYNC, 16'h0000, 32'h0000_0000);
   endtask

   // One random event of any class, noise included
   task automatic send_random_event();
      int          pick;
      logic [15:0] ecode;
      logic [15:0] etype;
      logic [31:0] evalue;
      pick   = $urandom_range(0, 99);
      ecode  = 16'($urandom);
      evalue = $urandom_range(0, 2) == 0 ? 32'h0 : $urandom;
      if (pick < 45) begin
         // Mostly keyboard usage codes, sometimes the full code range
         if ($urandom_range(0, 7) != 0)
            ecode[15:8] = 8'h00;
         send_event(EV_KEY, ecode, evalue);
      end else if (pick < 62) begin
         send_event(EV_KEY, CODE_LEFT_BUTTON + 16'($urandom_range(0, 2)), evalue);
      end else if (pick < 82) begin
         if ($urandom_range(0, 3) != 0)
            ecode = 16'($urandom_range(0, 1));
         send_event(EV_REL, ecode, $urandom);
      end else if (pick < 92) begin
         send_event(EV_SYNC, ecode, $urandom);
      end else begin
         etype = 16'($urandom);
         send_event(etype, ecode, $urandom);
      end
   endtask

   // A well-formed mouse report: some motion, maybe a button, then sync
   task automatic send_mouse_report();
      int moves;
      moves = $urandom_range(0, 4);
      repeat (moves)
         send_event(EV_REL, 16'($urandom_range(0, 1)), $urandom);
      if ($urandom_range(0, 2) == 0)
         send_event(EV_KEY, CODE_LEFT_BUTTON + 16'($urandom_range(0, 2)),
                    $urandom_range(0, 1) ? $urandom : 32'h0);
      send_event(EV_SYNC, 16'h0000, $urandom_range(0, 1) ? 32'h0 : $urandom);
   endtask

   // Random traffic in phases, each under its own mask setting, one of them flat out
   task automatic test_random_traffic();
      int goal;
      int half;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0:       load_masks(8'h00, 8'h00, 8'h00);
            1:       load_masks(8'hff, 8'hff, 8'hff);
            2:       load_masks(8'h01, 8'h02, 8'h04);
            3:       load_masks(8'h03, 8'h06, 8'h05);
            default: load_masks(8'($urandom), 8'($urandom), 8'($urandom));
         endcase
         // One phase runs flat out on both sides
         steady_flow = (phase == 2);
         goal = handled_events + RANDOM_EVENTS / RANDOM_PHASES;
         half = handled_events + RANDOM_EVENTS / (2 * RANDOM_PHASES);
         while (handled_events < goal) begin
            if ($urandom_range(0, 99) < 55)
               send_mouse_report();
            else
               send_random_event();
            // Midway through one phase, hold the sender until every result is back
            if (phase == 3 && handled_events >= half && half != 0) begin
               wait_idle();
               half = 0;
            end
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_key_events();
      test_buttons();
      test_relative();
      test_mask_registers();
      test_random_traffic();

      // Drain: everything accepted, wait for the last results plus settle time
      wait_idle();
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
